// ===== sv/lacat_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the lru age tracker; no dependencies
package lacat_pkg;

    // table geometry
    localparam int BLOCKS    = 256;
    localparam int IDX_W     = $clog2(BLOCKS);

    // field widths
    localparam int ADDR_W    = 16;
    localparam int LS_W      = 9;
    localparam int AGE_W     = 8;
    localparam int SPAN_W    = 9;
    localparam int OP_W      = 2;
    localparam int SUM_W     = IDX_W + SPAN_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ASSOC     = 2'd1;

    // reset values
    localparam logic [LS_W-1:0]  RESET_LINE = 9'd64;
    localparam logic [AGE_W-1:0] RESET_AGE  = 8'd8;

    // operation codes
    localparam logic [OP_W-1:0] OP_SINGLE = 2'd0;
    localparam logic [OP_W-1:0] OP_RANGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SPAN   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_sel_end;
        logic b_load;
        logic e_load;
        logic b_inc;
        logic old_load;
        logic hit_capture;
        logic pass_start;
        logic set_err;
        logic age_eq_all;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic q_oor;
        logic e_lt_b;
        logic b_eq_last;
        logic b_eq_e;
        logic age_absent;
        logic pass_done;
    } dp_stat_t;

endpackage

// ===== sv/lacat_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lacat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lacat_div.sv =====
// restoring divider, one quotient bit per cycle, byte address by line size
// depends on lacat_pkg
module lacat_div
    import lacat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [LS_W-1:0]   divisor,
    output logic              done,
    output logic [ADDR_W-1:0] quot
);

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LS_W-1:0]   rem_reg;
    logic [ADDR_W-1:0] quot_reg;
    logic [LS_W-1:0]   dvs_reg;

    logic [LS_W:0]     trial;
    logic [LS_W:0]     diff;
    logic              ge;

    // trial subtraction for the next quotient bit
    assign trial = {rem_reg, quot_reg[ADDR_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ADDR_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg  <= ge ? diff[LS_W-1:0] : trial[LS_W-1:0];
            quot_reg <= {quot_reg[ADDR_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== sv/lacat_dp.sv =====
// datapath: config registers, index registers, divider, age table and update pass
// depends on lacat_pkg, lacat_div, lacat_ram
module lacat_dp
    import lacat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [ADDR_W-1:0]     end_addr,
    input  logic [SPAN_W-1:0]     span_lines,
    input  logic                  may_mode,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  hit,
    output logic                  status
);

    // configuration
    logic [LS_W-1:0]   ls_reg;
    logic [AGE_W-1:0]  assoc_reg;

    // latched item
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              may_reg;

    // indexes and touch state
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  e_reg;
    logic [IDX_W-1:0]  last_reg;
    logic [AGE_W-1:0]  old_reg;
    logic              hit_reg;
    logic              status_reg;

    // update pass pipeline
    logic              pass_rd_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              wr_v_reg;
    logic [IDX_W-1:0]  wr_addr_reg;

    // entries written since reset
    logic [BLOCKS-1:0] valid_reg;
    logic              vld_q_reg;

    logic              div_done;
    logic [ADDR_W-1:0] quot;
    logic [LS_W-1:0]   divisor;
    logic [IDX_W-1:0]  q_idx;
    logic [SPAN_W-1:0] span_eff;
    logic [SUM_W-1:0]  last_sum;
    logic [IDX_W-1:0]  last_next;
    logic [IDX_W-1:0]  rd_addr;
    logic [AGE_W-1:0]  rdata;
    logic [AGE_W-1:0]  eff_age;
    logic [AGE_W-1:0]  wdata;
    logic              bump;

    // block index division, zero line size counts as one
    assign divisor = (ls_reg == '0) ? LS_W'(1) : ls_reg;

    lacat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_end ? end_reg : addr_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (quot)
    );

    assign q_idx = quot[IDX_W-1:0];

    // last block of a span, clipped to the table end
    assign span_eff  = (span_reg == '0) ? SPAN_W'(1) : span_reg;
    assign last_sum  = SUM_W'(q_idx) + SUM_W'(span_eff) - SUM_W'(1);
    assign last_next = (last_sum > SUM_W'(BLOCKS - 1)) ? IDX_W'(BLOCKS - 1)
                                                       : last_sum[IDX_W-1:0];

    // age table
    assign rd_addr = pass_rd_reg ? cnt_reg : b_reg;

    lacat_ram #(
        .WIDTH (AGE_W),
        .DEPTH (BLOCKS)
    ) u_age (
        .clk   (clk),
        .we    (wr_v_reg),
        .waddr (wr_addr_reg),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // unwritten entries read as the reset age
    assign eff_age = vld_q_reg ? rdata : RESET_AGE;

    // new age of one entry during the pass
    assign bump  = (eff_age < old_reg) || ((eff_age == old_reg) && (cmd.age_eq_all || may_reg));
    assign wdata = (wr_addr_reg == b_reg) ? '0
                 : (bump && (eff_age < assoc_reg)) ? eff_age + 1'b1
                 : eff_age;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ls_reg    <= RESET_LINE;
            assoc_reg <= RESET_AGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_SIZE: ls_reg    <= cfg_data[LS_W-1:0];
                REG_ASSOC:     assoc_reg <= cfg_data[AGE_W-1:0];
                default:       ;
            endcase
        end
    end

    // control registers of the pass and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_rd_reg <= 1'b0;
            cnt_reg     <= '0;
            wr_v_reg    <= 1'b0;
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            status_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.pass_start)
            begin
                pass_rd_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (pass_rd_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(BLOCKS - 1))
                begin
                    pass_rd_reg <= 1'b0;
                end
            end
            wr_v_reg <= pass_rd_reg;
            if (wr_v_reg)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (cmd.load_in)
            begin
                hit_reg    <= 1'b0;
                status_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_err)
                begin
                    status_reg <= 1'b1;
                end
                if (cmd.hit_capture)
                begin
                    hit_reg <= eff_age < assoc_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= cnt_reg;
        vld_q_reg   <= valid_reg[rd_addr];
        if (cmd.load_in)
        begin
            addr_reg <= addr;
            end_reg  <= end_addr;
            span_reg <= span_lines;
            may_reg  <= may_mode;
        end
        if (cmd.b_load)
        begin
            b_reg    <= q_idx;
            last_reg <= last_next;
        end
        else if (cmd.b_inc)
        begin
            b_reg <= b_reg + 1'b1;
        end
        if (cmd.e_load)
        begin
            e_reg <= q_idx;
        end
        if (cmd.old_load)
        begin
            old_reg <= eff_age;
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.div_done   = div_done;
        stat.q_oor      = quot >= ADDR_W'(BLOCKS);
        stat.e_lt_b     = q_idx < b_reg;
        stat.b_eq_last  = b_reg == last_reg;
        stat.b_eq_e     = b_reg == e_reg;
        stat.age_absent = eff_age >= assoc_reg;
        stat.pass_done  = wr_v_reg && (wr_addr_reg == IDX_W'(BLOCKS - 1));
    end

    assign hit    = hit_reg;
    assign status = status_reg;

endmodule

// ===== sv/lacat_ctrl.sv =====
// controller state machine sequencing division, span scan and update passes
// depends on lacat_pkg
module lacat_ctrl
    import lacat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    input  dp_stat_t        stat,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_B,
        S_WAIT_B,
        S_DIV_E,
        S_WAIT_E,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TOUCH_RD,
        S_TOUCH_OLD,
        S_PASS,
        S_ERR,
        S_DONE
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [OP_W-1:0] op_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.age_eq_all = op_reg == OP_RANGE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    case (op)
                        OP_SINGLE, OP_RANGE, OP_SPAN: state_next = S_DIV_B;
                        default:                      state_next = S_ERR;
                    endcase
                end
            end
            S_DIV_B:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (stat.div_done)
                begin
                    cmd.b_load = 1'b1;
                    if (stat.q_oor)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_RANGE: state_next = S_DIV_E;
                            OP_SPAN:  state_next = S_SCAN_RD;
                            default:  state_next = S_TOUCH_RD;
                        endcase
                    end
                end
            end
            S_DIV_E:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_end = 1'b1;
                state_next      = S_WAIT_E;
            end
            S_WAIT_E:
            begin
                cmd.div_sel_end = 1'b1;
                if (stat.div_done)
                begin
                    if (stat.q_oor)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.e_load = 1'b1;
                        state_next = stat.e_lt_b ? S_DONE : S_TOUCH_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = stat.b_eq_last ? S_TOUCH_RD : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.age_absent)
                begin
                    state_next = S_TOUCH_RD;
                end
                else
                begin
                    cmd.b_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_TOUCH_RD:
            begin
                state_next = S_TOUCH_OLD;
            end
            S_TOUCH_OLD:
            begin
                cmd.old_load    = 1'b1;
                cmd.hit_capture = op_reg != OP_RANGE;
                cmd.pass_start  = 1'b1;
                state_next      = S_PASS;
            end
            S_PASS:
            begin
                if (stat.pass_done)
                begin
                    if ((op_reg == OP_RANGE) && !stat.b_eq_e)
                    begin
                        cmd.b_inc  = 1'b1;
                        state_next = S_TOUCH_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ERR:
            begin
                cmd.set_err = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and latched op
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SINGLE;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_in)
            begin
                op_reg <= op;
            end
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

endmodule

// ===== sv/lru_age_cache_access_tracker_core.sv =====
// lru age tracker, top level joining controller and datapath
// depends on lacat_pkg, lacat_ctrl, lacat_dp
//
// usage
//   an item is taken at a rising edge with start high and busy low; busy
//   stays high until the result has been shown. the result (hit, status)
//   is valid for exactly one cycle while done is high; the receiver cannot
//   hold it off. op 0 touches one block, op 1 every block of a byte range,
//   op 2 the first absent block of a span or else its last block.
//   an item runs through the division of its base address, then per touched
//   block one read for the old age and one pass over the age table through
//   its one read and one write port, then the done state; the next item is
//   taken only once busy has fallen. op 1 adds a second division for the
//   range end and a read and a pass per block of its range; op 2 first scans
//   its span block by block from the base. a base index beyond the table, a
//   range end beyond it or an undefined op skips the touch and ends with
//   status set; an undefined op also skips the division.
//   configuration: cfg_valid/cfg_ready write channel, always ready, index 0
//   line size, index 1 associativity; write it only while idle.
//   reset: line size 64, associativity 8, every age reads as 8 through
//   per-entry valid bits, so no clearing sweep is needed.
module lru_age_cache_access_tracker_core
    import lacat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       op,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [ADDR_W-1:0]     end_addr,
    input  logic [SPAN_W-1:0]     span_lines,
    input  logic                  may_mode,
    output logic                  done,
    output logic                  hit,
    output logic                  status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing
    lacat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // storage and arithmetic
    lacat_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .addr       (addr),
        .end_addr   (end_addr),
        .span_lines (span_lines),
        .may_mode   (may_mode),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hit        (hit),
        .status     (status)
    );

endmodule

// ===== sv/lacat_chk.sv =====
// port-level checker for the lru age tracker, bound to the top level
// depends on lacat_pkg and lru_age_cache_access_tracker_core
module lacat_chk
    import lacat_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic status
);

    // an accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    // a result is never shown in the cycle after acceptance
    a_no_instant_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result shown too early");

    // results appear only while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result without item in flight");

    // one strobe per item, then idle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // an error never reports a hit
    a_err_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> !hit)
        else $error("hit reported with error status");

endmodule

bind lru_age_cache_access_tracker_core lacat_chk u_lacat_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .hit    (hit),
    .status (status)
);

// ===== bench/lru_age_cache_access_tracker_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the lru age tracker core: a directed table, then
// random items over several register settings, checked against an age table
// depends on lacat_pkg and lru_age_cache_access_tracker_core
module lru_age_cache_access_tracker_core_test;
    import lacat_pkg::*;

    // codes with no name in the package
    localparam logic [OP_W-1:0]      OP_UNDEF  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int END_WAIT     = 300;
    localparam int PEND_DEPTH   = 8;
    localparam int MAX_ROWS     = 32;

    // one item plus an optional fixed expectation
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] end_addr;
        logic [SPAN_W-1:0] span;
        logic              may;
        logic              fixed_exp;
        logic              exp_hit;
        logic              exp_status;
    } access_row_t;

    typedef struct packed {
        logic hit;
        logic status;
    } access_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       op;
    logic [ADDR_W-1:0]     addr;
    logic [ADDR_W-1:0]     end_addr;
    logic [SPAN_W-1:0]     span_lines;
    logic                  may_mode;
    logic                  done;
    logic                  hit;
    logic                  status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the age table and registers
    logic [AGE_W-1:0] age_shadow [BLOCKS];
    logic [LS_W-1:0]  line_shadow;
    logic [AGE_W-1:0] assoc_shadow;

    // expected results in order, as a ring with head and tail counts
    access_result_t pending_results [PEND_DEPTH];
    int             pend_head;
    int             pend_tail;

    access_row_t    directed_rows [MAX_ROWS];
    int             directed_count;

    int fail_count;
    int items_sent;
    int results_seen;
    int hits_seen;
    int config_writes;
    int cycle_count;
    int op_count [4];

    lru_age_cache_access_tracker_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .addr       (addr),
        .end_addr   (end_addr),
        .span_lines (span_lines),
        .may_mode   (may_mode),
        .done       (done),
        .hit        (hit),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // results still expected
    function automatic int pending_count();
        return pend_tail - pend_head;
    endfunction

    // line size with zero read as one
    function automatic int line_bytes();
        return (line_shadow == '0) ? 1 : int'(line_shadow);
    endfunction

    function automatic int block_index(logic [ADDR_W-1:0] a);
        return int'(a) / line_bytes();
    endfunction

    // zero the touched age, bump younger ones up to the associativity
    function automatic logic touch_block(int idx, bit age_equal);
        logic [AGE_W-1:0] old_age;
        int i;
        old_age = age_shadow[idx];
        age_shadow[idx] = '0;
        for (i = 0; i < BLOCKS; i++)
        begin
            if (i != idx && age_shadow[i] <= old_age
                && (age_shadow[i] != old_age || age_equal)
                && age_shadow[i] < assoc_shadow)
                age_shadow[i] = age_shadow[i] + 1'b1;
        end
        return old_age < assoc_shadow;
    endfunction

    // apply one item to the shadow table and give its result
    function automatic access_result_t predict_access(access_row_t r);
        access_result_t res;
        int b;
        int e;
        int k;
        int last;
        res = '0;
        b = block_index(r.addr);
        case (r.op)
            OP_SINGLE:
            begin
                if (b >= BLOCKS)
                    res.status = 1'b1;
                else
                    res.hit = touch_block(b, r.may);
            end
            OP_RANGE:
            begin
                e = block_index(r.end_addr);
                // range updates always age equal blocks too
                if (b >= BLOCKS || e >= BLOCKS)
                    res.status = 1'b1;
                else
                    for (k = b; k <= e; k++)
                        void'(touch_block(k, 1'b1));
            end
            OP_SPAN:
            begin
                if (b >= BLOCKS)
                    res.status = 1'b1;
                else
                begin
                    last = b + ((r.span == '0) ? 1 : int'(r.span)) - 1;
                    if (last > BLOCKS - 1)
                        last = BLOCKS - 1;
                    while (b < last && age_shadow[b] < assoc_shadow)
                        b++;
                    res.hit = touch_block(b, r.may);
                end
            end
            default:
                res.status = 1'b1;
        endcase
        return res;
    endfunction

    function automatic access_row_t mk_row(logic [OP_W-1:0] o, logic [ADDR_W-1:0] a,
                                           logic [ADDR_W-1:0] ea, logic [SPAN_W-1:0] s,
                                           logic m, logic fx, logic h, logic st);
        access_row_t r;
        r = '{o, a, ea, s, m, fx, h, st};
        return r;
    endfunction

    // append one row to the directed table
    task automatic add_row(logic [OP_W-1:0] o, logic [ADDR_W-1:0] a,
                           logic [ADDR_W-1:0] ea, logic [SPAN_W-1:0] s,
                           logic m, logic fx, logic h, logic st);
        directed_rows[directed_count] = mk_row(o, a, ea, s, m, fx, h, st);
        directed_count++;
    endtask

    // byte address somewhere inside block b
    function automatic logic [ADDR_W-1:0] line_addr(int b, int ls);
        return ADDR_W'(b * ls + $urandom_range(0, ls - 1));
    endfunction

    // mostly a small hot set, so that ages interact
    function automatic int pick_block();
        if ($urandom_range(0, 2) != 0)
            return $urandom_range(0, 23);
        return $urandom_range(0, BLOCKS - 1);
    endfunction

    // one of the defined ops
    function automatic logic [OP_W-1:0] pick_op();
        case ($urandom_range(0, 2))
            0: return OP_SINGLE;
            1: return OP_RANGE;
            default: return OP_SPAN;
        endcase
    endfunction

    function automatic access_row_t random_row();
        access_row_t r;
        int ls;
        int b;
        int e;
        int pick;
        ls = line_bytes();
        r = '0;
        r.may = 1'($urandom_range(0, 1));
        r.end_addr = ADDR_W'($urandom);
        r.span = SPAN_W'($urandom_range(1, 16));
        b = pick_block();
        r.addr = line_addr(b, ls);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.op = OP_SINGLE;
        else if (pick < 70)
        begin
            r.op = OP_SPAN;
            if ($urandom_range(0, 7) == 0)
                r.span = SPAN_W'($urandom);
        end
        else if (pick < 93)
        begin
            // short ranges keep the run length down
            r.op = OP_RANGE;
            e = b + (($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3));
            if (e > BLOCKS - 1)
                e = BLOCKS - 1;
            if ($urandom_range(0, 9) == 0 && b > 0)
                e = $urandom_range(0, b - 1);
            r.end_addr = line_addr(e, ls);
        end
        else if (pick < 97 && 65535 / ls >= BLOCKS)
        begin
            // index beyond the table on the base or the range end
            r.op = pick_op();
            if (r.op == OP_RANGE && $urandom_range(0, 1) == 0)
                r.end_addr = ADDR_W'($urandom_range(BLOCKS * ls, 65535));
            else
                r.addr = ADDR_W'($urandom_range(BLOCKS * ls, 65535));
            r.span = SPAN_W'($urandom);
        end
        else
        begin
            // undefined op with noise on every field
            r.op = OP_UNDEF;
            r.addr = ADDR_W'($urandom);
            r.span = SPAN_W'($urandom);
        end
        return r;
    endfunction

    // present an item and wait for it to be taken
    task automatic send_item(access_row_t r);
        access_result_t res;
        @(negedge clk);
        start      = 1'b1;
        op         = r.op;
        addr       = r.addr;
        end_addr   = r.end_addr;
        span_lines = r.span;
        may_mode   = r.may;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = predict_access(r);
        if (r.fixed_exp)
        begin
            res.hit    = r.exp_hit;
            res.status = r.exp_status;
        end
        pending_results[pend_tail % PEND_DEPTH] = res;
        pend_tail++;
        op_count[r.op]++;
        items_sent++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // hold off until every outstanding result is back and the core is idle
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_count() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_LINE_SIZE)
            line_shadow = data[LS_W-1:0];
        else if (idx == REG_ASSOC)
            assoc_shadow = data[AGE_W-1:0];
        config_writes++;
    endtask

    task automatic set_config(logic [LS_W-1:0] ls, logic [AGE_W-1:0] assoc, bit spare);
        write_register(REG_LINE_SIZE, ls);
        // top data bit is unused for the associativity
        write_register(REG_ASSOC, {1'($urandom_range(0, 1)), assoc});
        if (spare)
            write_register(REG_SPARE, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // directed table at reset settings: 64 byte lines, 8 ways
    task automatic load_directed();
        // first touch misses, second touch of the same line hits
        add_row(OP_SINGLE, 16'h0000, 16'h0000, 9'd1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h003F, 16'hFFFF, 9'd1, 1'b0, 1'b1, 1'b1, 1'b0);
        // index beyond the table and the undefined op
        add_row(OP_SINGLE, 16'hFFFF, 16'h0000, 9'd1, 1'b1, 1'b1, 1'b0, 1'b1);
        add_row(OP_UNDEF, 16'h0000, 16'h0000, 9'd0, 1'b0, 1'b1, 1'b0, 1'b1);
        add_row(OP_RANGE, 16'h0000, 16'hFFFF, 9'd1, 1'b0, 1'b1, 1'b0, 1'b1);
        add_row(OP_RANGE, 16'h3FC0, 16'h4000, 9'd1, 1'b1, 1'b1, 1'b0, 1'b1);
        add_row(OP_SPAN, 16'hFFFF, 16'h0000, 9'h1FF, 1'b1, 1'b1, 1'b0, 1'b1);
        add_row(OP_SINGLE, 16'h4000, 16'h0000, 9'd1, 1'b0, 1'b1, 1'b0, 1'b1);
        // reversed range leaves the table alone
        add_row(OP_RANGE, 16'h0200, 16'h000A, 9'd1, 1'b0, 1'b1, 1'b0, 1'b0);
        // ordinary traffic, checked by the shadow table
        add_row(OP_RANGE, 16'h0040, 16'h0147, 9'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h00C0, 16'h0000, 9'd1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h0080, 16'h0000, 9'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h0100, 16'h0000, 9'd1, 1'b1, 1'b0, 1'b0, 1'b0);
        // zero span, short span, span past the table end, widest span
        add_row(OP_SPAN, 16'h0000, 16'h0000, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(OP_SPAN, 16'h0000, 16'h0000, 9'd8, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(OP_SPAN, 16'h3E80, 16'h0000, 9'd300, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(OP_SPAN, 16'h0000, 16'hFFFF, 9'h1FF, 1'b0, 1'b0, 1'b0, 1'b0);
        // single block range and the last table block
        add_row(OP_RANGE, 16'h0000, 16'h0000, 9'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h3FFF, 16'h0000, 9'd1, 1'b1, 1'b0, 1'b0, 1'b0);
        // whole table as one range
        add_row(OP_RANGE, 16'h0000, 16'h3FFF, 9'd1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(OP_SPAN, 16'h3FC0, 16'h0000, 9'd256, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(OP_SINGLE, 16'h0000, 16'h0000, 9'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_count() == 0)
                report("result arrived with no item outstanding");
            else
            begin
                want = pending_results[pend_head % PEND_DEPTH];
                pend_head++;
                if (hit !== want.hit)
                    report($sformatf("result %0d hit %b, expected %b", results_seen, hit,
                                     want.hit));
                if (status !== want.status)
                    report($sformatf("result %0d status %b, expected %b", results_seen,
                                     status, want.status));
                results_seen++;
                if (hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [LS_W-1:0]  phase_line  [PHASES];
        logic [AGE_W-1:0] phase_assoc [PHASES];
        int per_phase;
        int p;
        int n;
        int i;

        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_SINGLE;
        addr       = '0;
        end_addr   = '0;
        span_lines = '0;
        may_mode   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_LINE_SIZE;
        cfg_data   = '0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        hits_seen  = 0;
        config_writes = 0;
        pend_head  = 0;
        pend_tail  = 0;
        directed_count = 0;
        for (i = 0; i < 4; i++)
            op_count[i] = 0;
        line_shadow  = RESET_LINE;
        assoc_shadow = RESET_AGE;
        for (i = 0; i < BLOCKS; i++)
            age_shadow[i] = RESET_AGE;

        // settings per phase, extremes and zero line size among them
        phase_line  = '{9'd1, 9'd256, 9'd0, 9'd16, 9'd7, 9'd100, 9'd32,
                        LS_W'($urandom_range(1, 256))};
        phase_assoc = '{8'd1, 8'd255, 8'd4, 8'd2, 8'd16, 8'd3, 8'd8,
                        AGE_W'($urandom_range(1, 255))};
        per_phase = RANDOM_ITEMS / PHASES;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        load_directed();
        for (i = 0; i < directed_count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 19));
            send_item(directed_rows[i]);
        end
        drain_results();

        // random part, no idling in the last phase
        for (p = 0; p < PHASES; p++)
        begin
            set_config(phase_line[p], phase_assoc[p], p == 2);
            for (n = 0; n < per_phase; n++)
            begin
                if (p != PHASES - 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                        idle_cycles($urandom_range(1, 19));
                    if ($urandom_range(0, 79) == 0)
                        drain_results();
                end
                send_item(random_row());
            end
            drain_results();
        end

        repeat (END_WAIT) @(posedge clk);

        $display("covered %0d items: %0d single, %0d range, %0d span, %0d undefined",
                 items_sent, op_count[OP_SINGLE], op_count[OP_RANGE], op_count[OP_SPAN],
                 op_count[OP_UNDEF]);
        $display("%0d results checked (%0d hits) over %0d register writes in %0d cycles",
                 results_seen, hits_seen, config_writes, cycle_count);
        if (fail_count == 0 && pending_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
